### rtl/tpc_pkg.sv
// ============================================================================
// Touch calibration package
// Shared constants, types and sequencer step codes for the calibration core.
// ============================================================================
package tpc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int OUT_W    = 16;
    localparam int NUM_REGS = 6;
    localparam int INDEX_W  = 3;
    localparam int OPA_W    = 25;
    localparam int OPB_W    = 14;
    localparam int PROD_W   = OPA_W + OPB_W;
    localparam int ACC_W    = 40;
    localparam int DIV_W    = 28;
    localparam int COEF_W   = 24;
    localparam int TMP_W    = 25;
    localparam int DSH_W    = DIV_W - 1 + OUT_W - 1;

    localparam logic [INDEX_W-1:0] REG_SCREEN_X0 = 3'd0;
    localparam logic [INDEX_W-1:0] REG_SCREEN_Y0 = 3'd1;
    localparam logic [INDEX_W-1:0] REG_SCREEN_X1 = 3'd2;
    localparam logic [INDEX_W-1:0] REG_SCREEN_Y1 = 3'd3;
    localparam logic [INDEX_W-1:0] REG_SCREEN_X2 = 3'd4;
    localparam logic [INDEX_W-1:0] REG_SCREEN_Y2 = 3'd5;

    localparam logic signed [OPA_W-1:0] W_45  = 25'sd45;
    localparam logic signed [OPA_W-1:0] W_110 = 25'sd110;
    localparam logic signed [OPA_W-1:0] W_115 = 25'sd115;
    localparam logic signed [OPA_W-1:0] W_385 = 25'sd385;
    localparam logic signed [OPB_W-1:0] V_45  = 14'sd45;
    localparam logic signed [OPB_W-1:0] V_160 = 14'sd160;
    localparam logic signed [OPB_W-1:0] V_270 = 14'sd270;
    localparam logic signed [OPB_W-1:0] V_430 = 14'sd430;

    typedef logic [NUM_REGS-1:0][SAMPLE_W-1:0] scr_array_t;

    typedef enum logic [4:0] {
        STP_K0, STP_K1, STP_A, STP_B, STP_D0, STP_D1, STP_E0, STP_E1,
        STP_Q0, STP_Q1, STP_R0, STP_R1, STP_W0, STP_W1,
        STP_CX0, STP_CX1, STP_CX2, STP_CY0, STP_CY1, STP_CY2,
        STP_NX0, STP_NX1, STP_NY0, STP_NY1
    } step_t;

    typedef struct packed {
        logic  issue;
        step_t step;
    } mac_cmd_t;

endpackage

### rtl/tpc_if.sv
// ============================================================================
// Touch calibration stream interfaces
// Valid/ready channels for raw samples and calibrated points.
// ============================================================================
interface tpc_sample_if
    import tpc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink (input valid, input adc_sample, output ready);
endinterface

interface tpc_point_if
    import tpc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] display_x;
    logic [OUT_W-1:0] display_y;
    logic             calibrated;

    modport source (output valid, output display_x, output display_y,
                    output calibrated, input ready);
    modport sink (input valid, input display_x, input display_y,
                  input calibrated, output ready);
endinterface

### rtl/tpc_arith.sv
// ============================================================================
// Touch calibration multiply-accumulate unit
// One shared multiplier and accumulator that derive the coefficients and
// the two numerators, one product per issued step.
// ============================================================================
module tpc_arith
    import tpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_cmd_t                 cmd,
    input  scr_array_t               scr,
    input  logic [SAMPLE_W-1:0]      raw_x,
    input  logic [SAMPLE_W-1:0]      raw_y,
    output logic signed [DIV_W-1:0]  k,
    output logic signed [ACC_W-1:0]  numx,
    output logic signed [ACC_W-1:0]  numy
);

    logic signed [OPB_W-1:0]  ux0, uy0, ux1, uy1, ux2, uy2, ux, uy;
    logic signed [OPB_W-1:0]  dx02, dx12, dy02, dy12, dy01, dx10;
    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod_reg;
    mac_cmd_t                 ctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     first, last, sub;
    logic signed [DIV_W-1:0]  k_reg;
    logic signed [COEF_W-1:0] a_reg, b_reg, d_reg, e_reg;
    logic signed [TMP_W-1:0]  q_reg, r_reg, w_reg;
    logic signed [ACC_W-1:0]  c_reg, f_reg, numx_reg, numy_reg;

    assign ux0  = $signed({2'b00, scr[REG_SCREEN_X0]});
    assign uy0  = $signed({2'b00, scr[REG_SCREEN_Y0]});
    assign ux1  = $signed({2'b00, scr[REG_SCREEN_X1]});
    assign uy1  = $signed({2'b00, scr[REG_SCREEN_Y1]});
    assign ux2  = $signed({2'b00, scr[REG_SCREEN_X2]});
    assign uy2  = $signed({2'b00, scr[REG_SCREEN_Y2]});
    assign ux   = $signed({2'b00, raw_x});
    assign uy   = $signed({2'b00, raw_y});
    assign dx02 = ux0 - ux2;
    assign dx12 = ux1 - ux2;
    assign dy02 = uy0 - uy2;
    assign dy12 = uy1 - uy2;
    assign dy01 = uy0 - uy1;
    assign dx10 = ux1 - ux0;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.step)
            STP_K0:  begin op_a = OPA_W'(dx02);  op_b = dy12;  end
            STP_K1:  begin op_a = OPA_W'(dx12);  op_b = dy02;  end
            STP_A:   begin op_a = W_385;         op_b = dy01;  end
            STP_B:   begin op_a = W_385;         op_b = dx10;  end
            STP_D0:  begin op_a = W_115;         op_b = dy12;  end
            STP_D1:  begin op_a = W_110;         op_b = dy02;  end
            STP_E0:  begin op_a = W_110;         op_b = dx02;  end
            STP_E1:  begin op_a = W_115;         op_b = dx12;  end
            STP_Q0:  begin op_a = OPA_W'(ux0);   op_b = uy1;   end
            STP_Q1:  begin op_a = OPA_W'(ux1);   op_b = uy0;   end
            STP_R0:  begin op_a = OPA_W'(ux2);   op_b = uy0;   end
            STP_R1:  begin op_a = OPA_W'(ux0);   op_b = uy2;   end
            STP_W0:  begin op_a = OPA_W'(ux1);   op_b = uy2;   end
            STP_W1:  begin op_a = OPA_W'(ux2);   op_b = uy1;   end
            STP_CX0: begin op_a = r_reg;         op_b = V_45;  end
            STP_CX1: begin op_a = w_reg;         op_b = V_45;  end
            STP_CX2: begin op_a = q_reg;         op_b = V_430; end
            STP_CY0: begin op_a = r_reg;         op_b = V_270; end
            STP_CY1: begin op_a = w_reg;         op_b = V_45;  end
            STP_CY2: begin op_a = q_reg;         op_b = V_160; end
            STP_NX0: begin op_a = OPA_W'(a_reg); op_b = ux;    end
            STP_NX1: begin op_a = OPA_W'(b_reg); op_b = uy;    end
            STP_NY0: begin op_a = OPA_W'(d_reg); op_b = ux;    end
            STP_NY1: begin op_a = OPA_W'(e_reg); op_b = uy;    end
            default: begin op_a = '0;            op_b = '0;    end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= cmd;
        end
    end

    always_comb
    begin
        first = 1'b0;
        last  = 1'b0;
        sub   = 1'b0;
        unique case (ctl_reg.step) inside
            STP_K0, STP_Q0, STP_R0, STP_W0, STP_CX0, STP_CY0,
            STP_NX0, STP_NY0:           first = 1'b1;
            STP_A, STP_B:               begin first = 1'b1; last = 1'b1; end
            STP_D0:                     begin first = 1'b1; sub = 1'b1; end
            STP_E0:                     first = 1'b1;
            STP_K1, STP_Q1, STP_R1,
            STP_W1, STP_D1:             begin last = 1'b1; sub = 1'b1; end
            STP_E1, STP_CX2, STP_CY2,
            STP_NX1, STP_NY1:           last = 1'b1;
            STP_CX1, STP_CY1:           last = 1'b0;
            default:                    last = 1'b0;
        endcase
    end

    always_comb
    begin
        if (ctl_reg.step == STP_NX0)
        begin
            base = c_reg;
        end
        else if (ctl_reg.step == STP_NY0)
        begin
            base = f_reg;
        end
        else if (first)
        begin
            base = '0;
        end
        else
        begin
            base = acc_reg;
        end
        acc_next = sub ? base - ACC_W'(prod_reg) : base + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl_reg.issue)
        begin
            acc_reg <= acc_next;
            if (last)
            begin
                case (ctl_reg.step)
                    STP_A:   a_reg    <= acc_next[COEF_W-1:0];
                    STP_B:   b_reg    <= acc_next[COEF_W-1:0];
                    STP_D1:  d_reg    <= acc_next[COEF_W-1:0];
                    STP_E1:  e_reg    <= acc_next[COEF_W-1:0];
                    STP_Q1:  q_reg    <= acc_next[TMP_W-1:0];
                    STP_R1:  r_reg    <= acc_next[TMP_W-1:0];
                    STP_W1:  w_reg    <= acc_next[TMP_W-1:0];
                    STP_CX2: c_reg    <= acc_next;
                    STP_CY2: f_reg    <= acc_next;
                    STP_NX1: numx_reg <= acc_next;
                    STP_NY1: numy_reg <= acc_next;
                    default: begin end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (ctl_reg.issue && ctl_reg.step == STP_K1)
        begin
            k_reg <= acc_next[DIV_W-1:0];
        end
    end

    assign k    = k_reg;
    assign numx = numx_reg;
    assign numy = numy_reg;

endmodule

### rtl/tpc_div.sv
// ============================================================================
// Touch calibration divider
// Signed divide, truncating toward zero, saturated to 0..65535, one
// quotient bit per cycle.
// ============================================================================
module tpc_div
    import tpc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] num,
    input  logic signed [DIV_W-1:0] den,
    output logic                    done,
    output logic [OUT_W-1:0]        quot
);

    logic                busy_reg, chk_reg, neg_reg, done_reg;
    logic [3:0]          cnt_reg;
    logic [ACC_W-1:0]    rem_reg;
    logic [DSH_W-1:0]    dsh_reg;
    logic [OUT_W-1:0]    q_reg;
    logic [ACC_W-1:0]    nmag;
    logic [DIV_W-2:0]    dmag;
    logic signed [DIV_W-1:0] dneg;
    logic                ge;

    assign nmag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    assign dneg = -den;
    assign dmag = den[DIV_W-1] ? dneg[DIV_W-2:0] : den[DIV_W-2:0];
    assign ge   = {2'b00, rem_reg} >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            chk_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                chk_reg  <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg && chk_reg)
            begin
                chk_reg <= 1'b0;
                if (neg_reg || ({3'b000, rem_reg} >= {dsh_reg, 1'b0}))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rem_reg <= nmag;
            dsh_reg <= {dmag, 15'b0};
            neg_reg <= num[ACC_W-1] ^ den[DIV_W-1];
            q_reg   <= '0;
        end
        else if (busy_reg && chk_reg)
        begin
            if (neg_reg)
            begin
                q_reg <= '0;
            end
            else
            begin
                q_reg <= '1;
            end
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg[ACC_W-1:0];
            end
            q_reg   <= {q_reg[OUT_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### rtl/touch_three_point_calibration_core.sv
// ============================================================================
// Touch three-point calibration core
// Pairs raw X/Y samples and maps each pair to display coordinates with an
// affine calibration derived from three touched reference points.
//
// Channel   Dir  Payload                              Transfer
// samples   in   adc_sample[11:0]                     valid & ready
// points    out  display_x, display_y, calibrated     valid & ready
// cfg       in   cfg_index[2:0], cfg_data[11:0]       cfg_we
//
// An X sample is only held. A Y sample runs the shared multiplier steps,
// first the calibration steps if the registers changed since the last point,
// then two divides of up to 16 steps; a zero divisor passes the raw pair.
// Reset clears the screen registers, the divisor and the X/Y pairing.
// A stalled result waits in the output register; the next sample is taken
// meanwhile, and a finished point waits for that register.
// ============================================================================
module touch_three_point_calibration_core
    import tpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    tpc_sample_if.sink          samples,
    tpc_point_if.source         points,
    input  logic                cfg_we,
    input  logic [INDEX_W-1:0]  cfg_index,
    input  logic [SAMPLE_W-1:0] cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CAL   = 7'b0000010,
        S_MAP   = 7'b0000100,
        S_FLUSH = 7'b0001000,
        S_DIVX  = 7'b0010000,
        S_DIVY  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t                  state_reg;
    step_t                   step_reg;
    scr_array_t              scr_reg;
    logic                    phase_reg, dirty_reg, out_valid_reg;
    logic [SAMPLE_W-1:0]     held_x_reg, y_reg;
    logic [OUT_W-1:0]        rx_reg, ry_reg, dx_out_reg, dy_out_reg;
    logic                    rcal_reg, cal_out_reg;
    mac_cmd_t                cmd;
    logic signed [DIV_W-1:0] k;
    logic signed [ACC_W-1:0] numx, numy;
    logic                    div_start, div_done;
    logic [OUT_W-1:0]        quot;
    logic                    accept, abort, out_load;

    assign accept    = samples.valid && samples.ready;
    assign abort     = (state_reg == S_MAP) && (step_reg == STP_NX0) && (k == '0);
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || points.ready);
    assign cmd.issue = (state_reg == S_CAL) || ((state_reg == S_MAP) && !abort);
    assign cmd.step  = step_reg;
    assign div_start = (state_reg == S_FLUSH) || ((state_reg == S_DIVX) && div_done);

    tpc_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .scr   (scr_reg),
        .raw_x (held_x_reg),
        .raw_y (y_reg),
        .k     (k),
        .numx  (numx),
        .numy  (numy)
    );

    tpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ((state_reg == S_FLUSH) ? numx : numy),
        .den   (k),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_reg   <= '0;
            dirty_reg <= 1'b0;
        end
        else if (cfg_we && (cfg_index < INDEX_W'(NUM_REGS)))
        begin
            scr_reg[cfg_index] <= cfg_data;
            dirty_reg          <= 1'b1;
        end
        else if (accept && phase_reg)
        begin
            dirty_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= STP_K0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (points.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        phase_reg <= !phase_reg;
                        if (phase_reg)
                        begin
                            state_reg <= dirty_reg ? S_CAL : S_MAP;
                            step_reg  <= dirty_reg ? STP_K0 : STP_NX0;
                        end
                    end
                end
                S_CAL:
                begin
                    step_reg <= step_t'(step_reg + 5'd1);
                    if (step_reg == STP_CY2)
                    begin
                        state_reg <= S_MAP;
                    end
                end
                S_MAP:
                begin
                    if (abort)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (step_reg == STP_NY1)
                    begin
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        step_reg <= step_t'(step_reg + 5'd1);
                    end
                end
                S_FLUSH:
                begin
                    state_reg <= S_DIVX;
                end
                S_DIVX:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !phase_reg)
        begin
            held_x_reg <= samples.adc_sample;
        end
        if (accept && phase_reg)
        begin
            y_reg <= samples.adc_sample;
        end
        if (abort)
        begin
            rx_reg   <= OUT_W'(held_x_reg);
            ry_reg   <= OUT_W'(y_reg);
            rcal_reg <= 1'b0;
        end
        if ((state_reg == S_DIVX) && div_done)
        begin
            rx_reg <= quot;
        end
        if ((state_reg == S_DIVY) && div_done)
        begin
            ry_reg   <= quot;
            rcal_reg <= 1'b1;
        end
        if (out_load)
        begin
            dx_out_reg  <= rx_reg;
            dy_out_reg  <= ry_reg;
            cal_out_reg <= rcal_reg;
        end
    end

    assign samples.ready     = (state_reg == S_IDLE);
    assign points.valid      = out_valid_reg;
    assign points.display_x  = dx_out_reg;
    assign points.display_y  = dy_out_reg;
    assign points.calibrated = cal_out_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register is not one-hot");

    a_y_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg) |=> !samples.ready)
        else $error("Y sample did not start a mapping");

    a_x_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !phase_reg && !out_valid_reg) |=> !out_valid_reg)
        else $error("X sample produced a result");

    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("finished point was not presented");

endmodule

### dv/tb_touch_three_point_calibration_core.sv
// ============================================================================
// Touch three-point calibration core testbench
// Drives raw X/Y sample pairs through the sample channel, writes the screen
// registers between phases, predicts each calibrated point and checks every
// point transfer against the oldest prediction.
// ============================================================================
module tb_touch_three_point_calibration_core;
    import tpc_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] px;
        logic [OUT_W-1:0] py;
        logic             cal;
    } point_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [INDEX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0] cfg_data;

    tpc_sample_if samples ();
    tpc_point_if points ();

    touch_three_point_calibration_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .points    (points),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [SAMPLE_W-1:0] sample_queue[$];
    point_t              expected_points[$];
    longint              scr[NUM_REGS];
    bit                  want_y;
    longint              held_x;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  errors;
    bit                  driving;
    bit                  sample_taken;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint sat16(longint v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    // Signed division truncating toward zero.
    function automatic longint div_trunc(longint n, longint d);
        longint q;
        q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic void predict_point(logic [SAMPLE_W-1:0] s);
        longint tx[3];
        longint ty[3];
        longint x0, y0, x1, y1, x2, y2, k, a, b, c, d, e, f, y;
        point_t p;
        tx = '{45, 45, 430};
        ty = '{45, 270, 160};
        if (!want_y) begin
            held_x = s;
            want_y = 1'b1;
            return;
        end
        want_y = 1'b0;
        y = s;
        x0 = scr[0]; y0 = scr[1]; x1 = scr[2]; y1 = scr[3]; x2 = scr[4]; y2 = scr[5];
        k = (x0 - x2) * (y1 - y2) - (x1 - x2) * (y0 - y2);
        if (k == 0) begin
            p.px = OUT_W'(held_x);
            p.py = OUT_W'(y);
            p.cal = 1'b0;
        end else begin
            a = (tx[0] - tx[2]) * (y1 - y2) - (tx[1] - tx[2]) * (y0 - y2);
            b = (x0 - x2) * (tx[1] - tx[2]) - (tx[0] - tx[2]) * (x1 - x2);
            c = (x2 * tx[1] - x1 * tx[2]) * y0 + (x0 * tx[2] - x2 * tx[0]) * y1
                + (x1 * tx[0] - x0 * tx[1]) * y2;
            d = (ty[0] - ty[2]) * (y1 - y2) - (ty[1] - ty[2]) * (y0 - y2);
            e = (x0 - x2) * (ty[1] - ty[2]) - (ty[0] - ty[2]) * (x1 - x2);
            f = (x2 * ty[1] - x1 * ty[2]) * y0 + (x0 * ty[2] - x2 * ty[0]) * y1
                + (x1 * ty[0] - x0 * ty[1]) * y2;
            p.px = OUT_W'(sat16(div_trunc(a * held_x + b * y + c, k)));
            p.py = OUT_W'(sat16(div_trunc(d * held_x + e * y + f, k)));
            p.cal = 1'b1;
        end
        expected_points.push_back(p);
    endfunction

    // Sample driver; also drives the point ready.
    always @(negedge clk) begin
        if (rst_n) begin
            if (sample_taken || !samples.valid) begin
                if (driving && sample_queue.size() > 0
                    && $urandom_range(99, 0) >= send_idle_pct) begin
                    samples.valid <= 1'b1;
                    samples.adc_sample <= sample_queue.pop_front();
                end else begin
                    samples.valid <= 1'b0;
                    samples.adc_sample <= SAMPLE_W'($urandom);
                end
            end
            points.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Sample and point monitor.
    always @(posedge clk) begin
        point_t exp_p;
        sample_taken = rst_n && samples.valid && samples.ready;
        if (sample_taken) begin
            predict_point(samples.adc_sample);
        end
        if (rst_n && points.valid && points.ready) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected point x=%0d y=%0d cal=%0b", $time,
                         points.display_x, points.display_y, points.calibrated);
                errors++;
            end else begin
                exp_p = expected_points.pop_front();
                if (points.display_x !== exp_p.px) begin
                    $display("%0t: display_x expected %0d actual %0d", $time,
                             exp_p.px, points.display_x);
                    errors++;
                end
                if (points.display_y !== exp_p.py) begin
                    $display("%0t: display_y expected %0d actual %0d", $time,
                             exp_p.py, points.display_y);
                    errors++;
                end
                if (points.calibrated !== exp_p.cal) begin
                    $display("%0t: calibrated expected %0b actual %0b", $time,
                             exp_p.cal, points.calibrated);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        while (sample_queue.size() > 0 || samples.valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(int idx, int val);
        logic [SAMPLE_W-1:0] v;
        v = SAMPLE_W'(val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= INDEX_W'(idx);
        cfg_data <= v;
        if (idx < NUM_REGS)
            scr[idx] = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(int r0, int r1, int r2, int r3, int r4, int r5);
        write_reg(REG_SCREEN_X0, r0);
        write_reg(REG_SCREEN_Y0, r1);
        write_reg(REG_SCREEN_X1, r2);
        write_reg(REG_SCREEN_Y1, r3);
        write_reg(REG_SCREEN_X2, r4);
        write_reg(REG_SCREEN_Y2, r5);
    endtask

    task automatic add_pair(logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y);
        sample_queue.push_back(x);
        sample_queue.push_back(y);
    endtask

    task automatic random_pairs(int n);
        for (int i = 0; i < n; i++)
            add_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        samples.valid = 1'b0;
        samples.adc_sample = '0;
        points.ready = 1'b0;
        for (int i = 0; i < NUM_REGS; i++)
            scr[i] = 0;
        want_y = 1'b0;
        held_x = 0;
        errors = 0;
        driving = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Degenerate calibration after reset: raw points pass through.
        add_pair(12'h000, 12'hFFF);
        add_pair(12'hFFF, 12'h000);
        add_pair(12'hA5A, 12'h5A5);
        driving = 1'b1;
        drain();

        // A typical calibration, with extremes and out-of-range points.
        driving = 1'b0;
        write_all(300, 300, 300, 3700, 3800, 2000);
        write_reg(6, 12'h123);
        write_reg(7, 12'hFFF);
        add_pair(12'h000, 12'h000);
        add_pair(12'hFFF, 12'hFFF);
        add_pair(12'h000, 12'hFFF);
        add_pair(12'hFFF, 12'h000);
        add_pair(12'd300, 12'd300);
        add_pair(12'd3800, 12'd2000);
        add_pair(12'h555, 12'hAAA);
        driving = 1'b1;
        drain();

        // Inverted axes, which still give a positive divisor.
        driving = 1'b0;
        write_all(4095, 0, 4095, 4095, 0, 2048);
        add_pair(12'h000, 12'h000);
        add_pair(12'hFFF, 12'hFFF);
        add_pair(12'd2048, 12'd1024);
        driving = 1'b1;
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            driving = 1'b0;
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 55; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 55; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            write_all($urandom_range(4095, 0), $urandom_range(4095, 0),
                      $urandom_range(4095, 0), $urandom_range(4095, 0),
                      $urandom_range(4095, 0), $urandom_range(4095, 0));
            random_pairs(50);
            driving = 1'b1;
            drain();
            // Collinear points: zero divisor mid-run.
            driving = 1'b0;
            write_all(100 * ph, 100 * ph, 200 * ph + 1, 200 * ph + 1, 4095, 4095);
            random_pairs(20);
            driving = 1'b1;
            drain();
            driving = 1'b0;
            write_all(200 + $urandom_range(300, 0), 200 + $urandom_range(300, 0),
                      200 + $urandom_range(300, 0), 3500 + $urandom_range(500, 0),
                      3500 + $urandom_range(500, 0), 1500 + $urandom_range(1000, 0));
            random_pairs(30);
            driving = 1'b1;
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
